>>> rtl/rtle_pkg.sv
// Package: sizes, commands and status codes of the recurrent logit engine.
package rtle_pkg;
  localparam int HidW    = 64;
  localparam int VocabN  = 256;
  localparam int HidAW   = $clog2(HidW);
  localparam int TokW    = $clog2(VocabN);
  localparam int EmbWords  = VocabN * HidW;
  localparam int HidWords  = HidW * HidW;
  localparam int HeadWords = VocabN * HidW;
  localparam int EmbAW   = $clog2(EmbWords);
  localparam int HidMAW  = $clog2(HidWords);
  localparam int HeadAW  = $clog2(HeadWords);
  localparam int NumRes  = (VocabN + 3) / 4;
  localparam int ResAW   = (NumRes > 1) ? $clog2(NumRes) : 1;
  localparam int AccW    = 40;
  localparam int FracBits = 12;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_STEP   = 2'd2,
    CMD_FREE   = 2'd3
  } cmd_e;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_NOTREADY = 1'b1;

  function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    if (v < -40'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage

>>> rtl/recurrent_token_logit_engine_core.sv
// Top level: recurrent cell with output projection, one shared MAC over memories.
// Usage:
//  s_axis carries requests: tuser = cmd, tdata = {token, weight_value, weight_addr}.
//  Write (cmd 0), commit (1) and free (3) give no result. Commit sets ready
//  and clears hidden; free clears ready and hidden.
//  A step (2) gives NumRes results on m_axis (four logits each, tlast on the
//  final), or one result with tuser (status) 1 when not ready.
//  Dot products do one multiply-accumulate per cycle on the shared unit,
//  reading each memory once a cycle, unless a stall holds the projection.
//  Writes are stored on accept. One request is worked at a time; s_axis_tready is
//  low while busy. Results sit in an output register; a stall on m_axis
//  holds the projection until the register empties.
//  Reset clears ready and control; the hidden vector is cleared by commit
//  and free, and weight stores are undefined until written.
module recurrent_token_logit_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  input  logic [47:0] s_axis_tdata,  // weight_addr[15:0], weight_value[31:16], token[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tuser,  // status[0]
  output logic [71:0] m_axis_tdata,  // logit_base[7:0], logit_a..d[71:8] 16 bits each
  output logic        m_axis_tlast
);
  import rtle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SUM, S_MV, S_MVEND, S_UPD, S_HD, S_HDEND, S_PUSH
  } state_e;

  state_e state_q;
  logic ready_q;
  logic [HidAW:0] i_q;        // row / element counter
  logic [HidAW:0] j_q;        // column counter
  logic [TokW:0]  r_q;        // head row
  logic [1:0]     lane_q;
  logic [TokW-1:0] tok_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [15:0] lg_q [4];
  logic mac_v_q, ph_q;
  logic pend_st_q, pend_last_q;
  logic [7:0] pend_base_q;

  logic signed [15:0] emb_mem  [EmbWords];
  logic signed [15:0] hm_mem   [HidWords];
  logic signed [15:0] head_mem [HeadWords];
  logic signed [15:0] hid_mem  [HidW];
  logic signed [15:0] sum_mem  [HidW];
  logic signed [15:0] act_mem  [HidW];
  logic signed [15:0] emb_rd, hm_rd, head_rd, hid_rd, sum_rd, act_rd;

  logic [EmbAW-1:0]  emb_ra;
  logic [HidMAW-1:0] hm_ra;
  logic [HeadAW-1:0] head_ra;
  logic [HidAW-1:0]  vec_ra;

  logic [1:0]  in_cmd;
  logic [15:0] in_addr;
  logic signed [15:0] in_val, in_tok;
  assign in_cmd  = s_axis_tuser;
  assign in_addr = s_axis_tdata[15:0];
  assign in_val  = s_axis_tdata[31:16];
  assign in_tok  = s_axis_tdata[47:32];

  logic out_v_q, out_last_q, out_st_q;
  logic [7:0] out_base_q;
  logic signed [15:0] out_l_q [4];

  assign s_axis_tready = (state_q == S_IDLE);
  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  logic push;
  assign push = (state_q == S_PUSH) && (!out_v_q || m_axis_tready);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {out_l_q[3], out_l_q[2], out_l_q[1], out_l_q[0], out_base_q};

  // weight writes at the accept edge
  always_ff @(posedge clk_i) begin
    if (acc_in && in_cmd == CMD_WRITE) begin
      if (in_addr < 16'(EmbWords))
        emb_mem[in_addr[EmbAW-1:0]] <= in_val;
      else if (in_addr < 16'(EmbWords + HidWords))
        hm_mem[HidMAW'(in_addr - 16'(EmbWords))] <= in_val;
      else if (in_addr < 16'(EmbWords + HidWords + HeadWords))
        head_mem[HeadAW'(in_addr - 16'(EmbWords + HidWords))] <= in_val;
    end
  end

  assign vec_ra  = j_q[HidAW-1:0];
  assign emb_ra  = EmbAW'({tok_q, i_q[HidAW-1:0]});
  assign hm_ra   = HidMAW'({i_q[HidAW-1:0], j_q[HidAW-1:0]});
  assign head_ra = HeadAW'({r_q[TokW-1:0], j_q[HidAW-1:0]});

  always_ff @(posedge clk_i) begin
    emb_rd  <= emb_mem[emb_ra];
    hm_rd   <= hm_mem[hm_ra];
    head_rd <= head_mem[head_ra];
    hid_rd  <= hid_mem[(state_q == S_SUM || state_q == S_UPD) ? i_q[HidAW-1:0] : vec_ra];
    sum_rd  <= sum_mem[vec_ra];
    act_rd  <= act_mem[i_q[HidAW-1:0]];
  end

  logic head_ph;
  assign head_ph = (state_q == S_HD || state_q == S_HDEND);
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] mul_p;
  assign mul_a = head_ph ? head_rd : hm_rd;
  assign mul_b = head_ph ? hid_rd : sum_rd;
  assign mul_p = mul_a * mul_b;
  logic signed [AccW-1:0] prod, mac_sum;
  assign prod    = AccW'(mul_p);
  assign mac_sum = acc_q + prod;
  logic signed [15:0] dot_res;
  assign dot_res = sat16(mac_sum >>> FracBits);
  logic signed [16:0] upd;
  assign upd = (17'(hid_rd) + 17'(act_rd)) >>> 1;

  logic hid_we, sum_we, act_we;
  logic signed [15:0] hid_wd, sum_wd, act_wd;
  assign hid_we = (state_q == S_CLR) || (state_q == S_UPD && ph_q);
  assign hid_wd = (state_q == S_CLR) ? 16'sd0 : upd[15:0];
  assign sum_we = (state_q == S_SUM) && ph_q;
  assign sum_wd = sat16(AccW'(hid_rd) + AccW'(emb_rd));
  assign act_we = (state_q == S_MVEND);
  assign act_wd = dot_res[15] ? 16'sd0 : dot_res;

  always_ff @(posedge clk_i) begin
    if (hid_we) hid_mem[i_q[HidAW-1:0]] <= hid_wd;
    if (sum_we) sum_mem[i_q[HidAW-1:0]] <= sum_wd;
    if (act_we) act_mem[i_q[HidAW-1:0]] <= act_wd;
  end

  logic [TokW-1:0] tok_c;
  always_comb begin
    if (in_tok < 0) tok_c = '0;
    else if (in_tok > 16'(VocabN - 1)) tok_c = TokW'(VocabN - 1);
    else tok_c = in_tok[TokW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ready_q <= 1'b0; out_v_q <= 1'b0;
      i_q <= '0; j_q <= '0; r_q <= '0; lane_q <= '0; mac_v_q <= 1'b0; ph_q <= 1'b0;
      acc_q <= '0; out_last_q <= 1'b0; out_st_q <= 1'b0; out_base_q <= '0;
      pend_st_q <= 1'b0; pend_last_q <= 1'b0; pend_base_q <= '0;
      tok_q <= '0;
      for (int k = 0; k < 4; k++) begin
        lg_q[k] <= '0; out_l_q[k] <= '0;
      end
    end else begin
      if (push) begin
        out_v_q <= 1'b1;
        for (int k = 0; k < 4; k++) out_l_q[k] <= lg_q[k];
        out_st_q <= pend_st_q; out_base_q <= pend_base_q; out_last_q <= pend_last_q;
      end else if (m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (acc_in) begin
          i_q <= '0; j_q <= '0;
          unique case (cmd_e'(in_cmd))
            CMD_WRITE: ;
            CMD_COMMIT: begin ready_q <= 1'b1; state_q <= S_CLR; end
            CMD_FREE:   begin ready_q <= 1'b0; state_q <= S_CLR; end
            CMD_STEP: begin
              tok_q <= tok_c;
              if (!ready_q) begin
                pend_st_q <= ST_NOTREADY; pend_base_q <= '0; pend_last_q <= 1'b1;
                for (int k = 0; k < 4; k++) lg_q[k] <= '0;
                state_q <= S_PUSH;
              end else begin
                ph_q <= 1'b0; state_q <= S_SUM;
              end
            end
            default: ;
          endcase
        end
        S_CLR: begin
          if (i_q == (HidAW+1)'(HidW - 1)) state_q <= S_IDLE;
          i_q <= i_q + 1'b1;
        end
        S_SUM: begin
          // ph 0: issue read, ph 1: write sum
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (i_q == (HidAW+1)'(HidW - 1)) begin
              i_q <= '0; j_q <= '0; acc_q <= '0; mac_v_q <= 1'b0; state_q <= S_MV;
            end else i_q <= i_q + 1'b1;
          end
        end
        S_MV: begin
          mac_v_q <= 1'b1;
          if (mac_v_q) acc_q <= mac_sum;
          if (j_q == (HidAW+1)'(HidW - 1)) state_q <= S_MVEND;
          j_q <= j_q + 1'b1;
        end
        S_MVEND: begin
          acc_q <= '0; mac_v_q <= 1'b0; j_q <= '0;
          if (i_q == (HidAW+1)'(HidW - 1)) begin
            i_q <= '0; ph_q <= 1'b0; state_q <= S_UPD;
          end else begin
            i_q <= i_q + 1'b1; state_q <= S_MV;
          end
        end
        S_UPD: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (i_q == (HidAW+1)'(HidW - 1)) begin
              r_q <= '0; lane_q <= '0; j_q <= '0; acc_q <= '0; mac_v_q <= 1'b0;
              state_q <= S_HD;
            end else i_q <= i_q + 1'b1;
          end
        end
        S_HD: if (r_q >= (TokW+1)'(VocabN)) begin
          lg_q[lane_q] <= '0;
          lane_q <= lane_q + 1'b1;
          if (lane_q == 2'd3) begin
            pend_st_q <= ST_OK; pend_last_q <= 1'b1;
            pend_base_q <= 8'(r_q - (TokW+1)'(3)); state_q <= S_PUSH;
          end else r_q <= r_q + 1'b1;
        end else begin
          mac_v_q <= 1'b1;
          if (mac_v_q) acc_q <= mac_sum;
          if (j_q == (HidAW+1)'(HidW - 1)) state_q <= S_HDEND;
          j_q <= j_q + 1'b1;
        end
        S_HDEND: begin
          lg_q[lane_q] <= dot_res;
          acc_q <= '0; mac_v_q <= 1'b0; j_q <= '0;
          lane_q <= lane_q + 1'b1;
          if (lane_q == 2'd3) begin
            pend_st_q <= ST_OK;
            pend_last_q <= (r_q == (TokW+1)'(VocabN - 1));
            pend_base_q <= 8'(r_q - (TokW+1)'(3));
            state_q <= S_PUSH;
          end else begin
            r_q <= r_q + 1'b1; state_q <= S_HD;
          end
        end
        S_PUSH: if (push) begin
          if (pend_last_q) state_q <= S_IDLE;
          else begin
            r_q <= r_q + 1'b1; lane_q <= '0; state_q <= S_HD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_idle_no_out_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> (out_v_q && $stable(m_axis_tdata)))
    else $error("result dropped while stalled");
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("request taken while busy");
  a_lane_zero_at_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH && pend_st_q == ST_NOTREADY) |-> pend_last_q)
    else $error("error result not last");
endmodule

>>> sim/tb_recurrent_token_logit_engine_core.sv
// Testbench: weight load, commit/free and token steps, checked against a built-in predictor.
module tb_recurrent_token_logit_engine_core;
  import rtle_pkg::*;

  typedef struct {
    logic               status;
    logic [7:0]         base;
    logic signed [15:0] lg [4];
    logic               last;
  } logit_beat_t;

  class logit_scoreboard;
    logic signed [15:0] emb  [EmbWords];
    logic signed [15:0] hmat [HidWords];
    logic signed [15:0] head [HeadWords];
    logic signed [15:0] hid  [HidW];
    bit                 ready;
    logit_beat_t        pending [$];
    int                 errors;
    int                 beats;

    function logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function logic signed [15:0] row_dot(bit use_head, int row, logic signed [15:0] v [HidW]);
      longint acc;
      acc = 0;
      for (int i = 0; i < HidW; i++)
        acc += (use_head ? head[row*HidW+i] : hmat[row*HidW+i]) * longint'(v[i]);
      return clip16(acc >>> FracBits);
    endfunction

    function void note_request(cmd_e cmd, logic [15:0] addr, logic signed [15:0] wval,
                               logic signed [15:0] tok);
      logic signed [15:0] sum [HidW];
      logic signed [15:0] act;
      logit_beat_t        r;
      int                 t;
      int                 s;
      case (cmd)
        CMD_WRITE: begin
          if (addr < EmbWords) emb[addr] = wval;
          else if (addr < EmbWords + HidWords) hmat[addr - EmbWords] = wval;
          else if (addr < EmbWords + HidWords + HeadWords)
            head[addr - EmbWords - HidWords] = wval;
        end
        CMD_COMMIT, CMD_FREE: begin
          ready = (cmd == CMD_COMMIT);
          foreach (hid[i]) hid[i] = '0;
        end
        default: begin
          if (!ready) begin
            r.status = ST_NOTREADY; r.base = '0; r.last = 1'b1;
            foreach (r.lg[j]) r.lg[j] = '0;
            pending.push_back(r);
          end else begin
            t = tok < 0 ? 0 : (tok > VocabN - 1 ? VocabN - 1 : int'(tok));
            for (int i = 0; i < HidW; i++)
              sum[i] = clip16(longint'(hid[i]) + longint'(emb[t*HidW+i]));
            for (int i = 0; i < HidW; i++) begin
              act = row_dot(0, i, sum);
              if (act < 0) act = '0;
              s = int'(hid[i]) + int'(act);
              hid[i] = 16'(s >>> 1);
            end
            for (int k = 0; k < NumRes; k++) begin
              r.status = ST_OK; r.base = 8'(k*4); r.last = (k == NumRes - 1);
              for (int j = 0; j < 4; j++)
                r.lg[j] = (k*4 + j < VocabN) ? row_dot(1, k*4 + j, hid) : '0;
              pending.push_back(r);
            end
          end
        end
      endcase
    endfunction

    function void check_beat(logic [71:0] d, logic tu, logic tl);
      logit_beat_t e;
      logic [15:0] got [4];
      beats++;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: got %h status %b last %b", $time, d, tu, tl);
        errors++;
        return;
      end
      e = pending.pop_front();
      got[0] = d[23:8]; got[1] = d[39:24]; got[2] = d[55:40]; got[3] = d[71:56];
      if (tu !== e.status) begin
        $display("%0t status: exp %b act %b", $time, e.status, tu); errors++;
      end
      if (d[7:0] !== e.base) begin
        $display("%0t logit_base: exp %0d act %0d", $time, e.base, d[7:0]); errors++;
      end
      for (int j = 0; j < 4; j++)
        if (got[j] !== e.lg[j]) begin
          $display("%0t logit %0d at base %0d: exp %h act %h", $time, j, e.base, e.lg[j],
                   got[j]);
          errors++;
        end
      if (tl !== e.last) begin
        $display("%0t last: exp %b act %b", $time, e.last, tl); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tuser;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  recurrent_token_logit_engine_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logit_scoreboard sb = new();
  int  send_idle = 0;
  int  recv_stall = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  quiet = 0;
  int  n_steps = 0;
  int  n_writes = 0;
  bit  row_loaded [VocabN];

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= 60000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(cmd_e cmd, logic [15:0] addr, logic signed [15:0] wval,
                              logic signed [15:0] tok);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {tok, wval, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, addr, wval, tok);
    if (cmd == CMD_WRITE) n_writes++;
    if (cmd == CMD_STEP) n_steps++;
  endtask

  function automatic logic signed [15:0] rand_weight();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'(signed'($urandom_range(1023)) - 512);
  endfunction

  task automatic write_word(int addr);
    send_request(CMD_WRITE, 16'(addr), rand_weight(), 16'($urandom));
  endtask

  task automatic load_row(int t);
    for (int i = 0; i < HidW; i++) write_word(t*HidW + i);
    row_loaded[t] = 1'b1;
  endtask

  function automatic logic signed [15:0] pick_token();
    logic signed [15:0] tk;
    int c;
    do begin
      tk = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(VocabN - 1));
      c = tk < 0 ? 0 : (tk > VocabN - 1 ? VocabN - 1 : int'(tk));
    end while (!row_loaded[c]);
    return tk;
  endfunction

  task automatic step(logic signed [15:0] tok);
    send_request(CMD_STEP, 16'($urandom), 16'($urandom), tok);
  endtask

  task automatic control(cmd_e cmd);
    send_request(cmd, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no model yet: a step reports not ready, out-of-range writes vanish
    step(16'sd5);
    send_request(CMD_WRITE, 16'd36864, 16'sh7fff, '0);
    send_request(CMD_WRITE, 16'hffff, 16'sh8000, '0);

    for (int a = EmbWords; a < EmbWords + HidWords + HeadWords; a++) begin
      if (a == EmbWords + HidWords) send_idle = 46;
      write_word(a);
    end
    for (int t = 0; t < 8; t++) begin
      load_row(t);
      load_row(VocabN - 1 - t);
    end

    send_idle = 0; recv_stall = 46;
    send_request(CMD_WRITE, 16'd0, 16'sh7fff, '0);
    send_request(CMD_WRITE, 16'd1, 16'sh8000, '0);
    step(16'sd0);
    control(CMD_COMMIT);
    step(-16'sd32768);
    step(16'sd32767);
    hold_req <= hold_req + 1;
    step(16'sd255);
    step(16'sd3);
    control(CMD_FREE);
    step(16'sd0);
    control(CMD_COMMIT);
    step(16'sd250);

    for (int n = 0; n < 100; n++) begin
      case (n / 25)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 46; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 46; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      pick = $urandom_range(99);
      if (pick < 18) step(pick_token());
      else if (pick < 22) control(CMD_COMMIT);
      else if (pick < 24) control(CMD_FREE);
      else if (pick < 34)
        send_request(CMD_WRITE, 16'($urandom_range(65535, 36864)), rand_weight(),
                     16'($urandom));
      else if (pick < 60) write_word($urandom_range(EmbWords + HidWords + HeadWords - 1,
                                                    EmbWords));
      else write_word(($urandom_range(1) ? $urandom_range(7) : $urandom_range(255, 248)) * HidW
                      + $urandom_range(HidW - 1));
    end
    control(CMD_COMMIT);
    step(pick_token());
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Ran %0d weight writes and %0d token steps, %0d result beats checked,",
             n_writes, n_steps, sb.beats);
    $display("with commit/free, not-ready steps, clamped tokens and output back-pressure.");
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
